// File: rtl/hcc_pkg.sv
// ----------------------------------------------------------------------------
// hcc_pkg
// Shared types and constants of the hold-to-confirm controller.
// ----------------------------------------------------------------------------
package hcc_pkg;

  // Field widths
  localparam int unsigned OpW      = 3;
  localparam int unsigned PhaseW   = 3;
  localparam int unsigned ScreenW  = 3;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 16;

  // Reset value of the hold length register
  localparam logic [TicksW-1:0] HoldTicksRst = 16'd1000;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHoldTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDebugEn   = 2'd1;

  // Event codes
  typedef enum logic [OpW-1:0] {
    OP_START      = 3'd0,
    OP_TICK       = 3'd1,
    OP_PRESS      = 3'd2,
    OP_RELEASE    = 3'd3,
    OP_HOST_ACK   = 3'd4,
    OP_HOST_CANCEL = 3'd5,
    OP_HOST_INIT  = 3'd6,
    OP_DEBUG      = 3'd7
  } op_e;

  // Session phases
  typedef enum logic [PhaseW-1:0] {
    PH_IDLE      = 3'd0,
    PH_HOME      = 3'd1,
    PH_HOLDING   = 3'd2,
    PH_CONFIRMED = 3'd3,
    PH_FINISHED  = 3'd4
  } phase_e;

  // Screens shown to the user
  typedef enum logic [ScreenW-1:0] {
    SC_REQUEST       = 3'd0,
    SC_REQUEST_STILL = 3'd1,
    SC_ANIMATION     = 3'd2,
    SC_CONFIRMED     = 3'd3,
    SC_FINISHED      = 3'd4
  } screen_e;

  // One input event
  typedef struct packed {
    logic        decision_yes;
    logic        preset_acked;
    logic        immediate_mode;
    op_e         opcode;
  } item_t;

  // One result
  typedef struct packed {
    logic    by_debug;
    logic    host_reset;
    logic    approved;
    logic    session_done;
    screen_e screen;
    phase_e  phase;
  } res_t;

  // Configuration as seen by the session logic
  typedef struct packed {
    logic              debug_en;
    logic [TicksW-1:0] hold_ticks;
  } cfg_t;

endpackage

// File: rtl/hcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// hcc_cfg_regs
// Configuration registers: hold length and debug decision enable.
// ----------------------------------------------------------------------------
module hcc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [hcc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hcc_pkg::CfgDataW-1:0] cfg_data_i,
  output hcc_pkg::cfg_t                cfg_o
);
  import hcc_pkg::*;

  logic [TicksW-1:0] hold_ticks_q;
  logic              debug_en_q;

  // Writes are always taken
  assign cfg_ready_o = 1'b1;

  // Register file; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q <= HoldTicksRst;
      debug_en_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgHoldTicks: hold_ticks_q <= cfg_data_i[TicksW-1:0];
        CfgDebugEn:   debug_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o.hold_ticks = hold_ticks_q;
  assign cfg_o.debug_en   = debug_en_q;

endmodule

// File: rtl/hcc_in_reg.sv
// ----------------------------------------------------------------------------
// hcc_in_reg
// Input register stage of the event stream.
// ----------------------------------------------------------------------------
module hcc_in_reg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [hcc_pkg::InDataW-1:0] s_axis_tdata,
  input  logic                        advance_i,
  output logic                        valid_o,
  output hcc_pkg::item_t              item_o
);
  import hcc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;

  // The stage can load whenever it is empty or draining this cycle
  assign s_axis_tready = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (s_axis_tready) begin
      valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload capture on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// File: rtl/hcc_session.sv
// ----------------------------------------------------------------------------
// hcc_session
// Session state machine, hold countdown and per-event result logic.
// ----------------------------------------------------------------------------
module hcc_session (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  hcc_pkg::item_t item_i,
  input  hcc_pkg::cfg_t  cfg_i,
  output hcc_pkg::res_t  res_o
);
  import hcc_pkg::*;

  phase_e            phase_q, phase_d;
  screen_e           screen_q, screen_d;
  logic [TicksW-1:0] count_q, count_d;
  logic              armed_q, armed_d;
  logic              acked_q, acked_d;
  logic              fast_q, fast_d;
  logic              dbg_pend_q, dbg_pend_d;
  logic              dbg_choice_q, dbg_choice_d;

  logic              active;
  logic [TicksW-1:0] count_dec;
  logic [TicksW-1:0] load_val;
  logic              end_idle;
  logic              done, appr, hreset, dbg;

  assign active    = (phase_q == PH_HOME) || (phase_q == PH_HOLDING) ||
                     (phase_q == PH_CONFIRMED);
  assign count_dec = count_q - TicksW'(1);
  assign load_val  = (fast_q || (cfg_i.hold_ticks == '0)) ? TicksW'(1) : cfg_i.hold_ticks;

  // Result flags and whether the session falls back to idle
  always_comb begin
    done     = 1'b0;
    appr     = 1'b0;
    hreset   = 1'b0;
    dbg      = 1'b0;
    end_idle = 1'b0;
    if (item_i.opcode != OP_START && active) begin
      unique case (item_i.opcode) inside
        OP_RELEASE: begin
          if (phase_q == PH_CONFIRMED) begin
            done = 1'b1;
            appr = 1'b1;
          end
        end
        OP_HOST_ACK: begin
          if (dbg_pend_q) begin
            done     = 1'b1;
            appr     = dbg_choice_q;
            dbg      = 1'b1;
            end_idle = 1'b1;
          end
        end
        OP_HOST_CANCEL, OP_HOST_INIT: begin
          done     = 1'b1;
          hreset   = (item_i.opcode == OP_HOST_INIT);
          end_idle = 1'b1;
        end
        OP_DEBUG: begin
          if (cfg_i.debug_en && acked_q) begin
            done     = 1'b1;
            appr     = item_i.decision_yes;
            dbg      = 1'b1;
            end_idle = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    phase_d      = phase_q;
    screen_d     = screen_q;
    count_d      = count_q;
    armed_d      = armed_q;
    acked_d      = acked_q;
    fast_d       = fast_q;
    dbg_pend_d   = dbg_pend_q;
    dbg_choice_d = dbg_choice_q;
    if (item_i.opcode == OP_START) begin
      phase_d      = PH_HOME;
      screen_d     = SC_REQUEST;
      count_d      = '0;
      armed_d      = 1'b0;
      dbg_pend_d   = 1'b0;
      dbg_choice_d = 1'b0;
      acked_d      = item_i.preset_acked;
      fast_d       = item_i.immediate_mode;
    end else if (active) begin
      unique case (item_i.opcode)
        OP_TICK: begin
          if (armed_q) begin
            count_d = count_dec;
            if (count_dec == '0) begin
              armed_d  = 1'b0;
              phase_d  = PH_CONFIRMED;
              screen_d = SC_CONFIRMED;
            end
          end
        end
        OP_PRESS: begin
          if (acked_q && phase_q == PH_HOME) begin
            phase_d  = PH_HOLDING;
            screen_d = SC_ANIMATION;
            armed_d  = 1'b1;
            count_d  = load_val;
          end
        end
        OP_RELEASE: begin
          if (phase_q == PH_HOLDING) begin
            phase_d  = PH_HOME;
            screen_d = SC_REQUEST_STILL;
            armed_d  = 1'b0;
            count_d  = '0;
          end else if (phase_q == PH_CONFIRMED) begin
            phase_d    = PH_FINISHED;
            screen_d   = SC_FINISHED;
            armed_d    = 1'b0;
            count_d    = '0;
            dbg_pend_d = 1'b0;
          end
        end
        OP_HOST_ACK: begin
          acked_d = 1'b1;
        end
        OP_DEBUG: begin
          if (cfg_i.debug_en) begin
            dbg_pend_d   = 1'b1;
            dbg_choice_d = item_i.decision_yes;
          end
        end
        default: ;
      endcase
      // Cancel, initialise and debug endings drop the session
      if (end_idle) begin
        phase_d      = PH_IDLE;
        screen_d     = SC_REQUEST;
        count_d      = '0;
        armed_d      = 1'b0;
        dbg_pend_d   = 1'b0;
        dbg_choice_d = 1'b0;
      end
    end
  end

  // Result as seen after the event
  always_comb begin
    res_o.phase        = phase_d;
    res_o.screen       = screen_d;
    res_o.session_done = done;
    res_o.approved     = appr;
    res_o.host_reset   = hreset;
    res_o.by_debug     = dbg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      screen_q     <= SC_REQUEST;
      count_q      <= '0;
      armed_q      <= 1'b0;
      acked_q      <= 1'b0;
      fast_q       <= 1'b0;
      dbg_pend_q   <= 1'b0;
      dbg_choice_q <= 1'b0;
    end else if (fire_i) begin
      phase_q      <= phase_d;
      screen_q     <= screen_d;
      count_q      <= count_d;
      armed_q      <= armed_d;
      acked_q      <= acked_d;
      fast_q       <= fast_d;
      dbg_pend_q   <= dbg_pend_d;
      dbg_choice_q <= dbg_choice_d;
    end
  end

`ifndef SYNTH
  // An armed countdown only exists while holding, and never sits at zero
  a_armed_holding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> (phase_q == PH_HOLDING && count_q != '0))
    else $error("hold countdown armed outside holding phase or at zero");

  // A debug decision is only parked while the host has not acknowledged
  a_pend_unacked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbg_pend_q |-> !acked_q)
    else $error("debug decision pending after host acknowledge");

  // Session endings by initialise or debug leave the block idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (hreset || dbg)) |=> (phase_q == PH_IDLE && !armed_q))
    else $error("session ending did not return to idle");

  // Flags only come with a finished session
  a_flags_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (appr || hreset || dbg) |-> done)
    else $error("result flag without session end");
`endif

endmodule

// File: rtl/hold_to_confirm_controller_core.sv
// ----------------------------------------------------------------------------
// hold_to_confirm_controller_core
// Hold-to-confirm session controller with stream input and output.
// ----------------------------------------------------------------------------
// Usage:
//   Events (start, tick, press, release, host ack, cancel, initialise, debug
//   decision) arrive on the s_axis channel; each accepted transaction gives
//   exactly one result transaction on m_axis with the phase and screen after
//   the event and the session-end flags.
//   Configuration (hold length, debug enable) is written on the cfg channel,
//   which is always ready; the user must make writes only while no event is
//   in flight, which the block itself does not enforce.
//   An accepted event is held in the input register, processed by the
//   session logic and offered on m_axis from the result register.
//   Throughput: one event per cycle while m_axis_tready is high; the
//   single-pass state update between the two registers sets this figure.
//   Reset puts the session in idle with the request screen, hold length 1000
//   and debug decisions disabled; both channels come up empty.
//   When the receiver stalls, the result register holds its transaction and
//   the input register fills; s_axis_tready drops once both are full.
// ----------------------------------------------------------------------------
module hold_to_confirm_controller_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Event stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] opcode, [3] immediate_mode, [4] preset_acked, [5] decision_yes
  input  logic [hcc_pkg::InDataW-1:0]   s_axis_tdata,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] phase, [5:3] screen, [6] session_done, [7] approved,
  // [8] host_reset, [9] by_debug
  output logic [hcc_pkg::OutDataW-1:0]  m_axis_tdata,
  // Configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hcc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [hcc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import hcc_pkg::*;

  cfg_t  cfg;
  item_t item;
  res_t  res;
  res_t  res_q;
  logic  in_valid;
  logic  advance;
  logic  fire;
  logic  out_valid_q, out_valid_d;

  hcc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hcc_in_reg u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance_i     (advance),
    .valid_o       (in_valid),
    .item_o        (item)
  );

  hcc_session u_session (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // The result register can take a new transaction when empty or being read
  assign advance = !out_valid_q || m_axis_tready;
  assign fire    = in_valid && advance;

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(res_q);

endmodule

// File: bench/hcc_session_checker.sv
// ----------------------------------------------------------------------------
// hcc_session_checker
// Watches the event, result and configuration channels of the hold-to-confirm
// controller. It keeps its own copy of the session state, works out the
// result of every accepted event and compares each result transaction, field
// by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module hcc_session_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [hcc_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [hcc_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_o,
  input  logic [hcc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hcc_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  outstanding_o
);
  import hcc_pkg::*;

  // Mirror of the controller's registers and session state.
  logic [TicksW-1:0] hold_len;
  logic              debug_allowed;
  phase_e            sess_phase;
  screen_e           sess_screen;
  logic [TicksW-1:0] countdown;
  logic              countdown_armed;
  logic              acked;
  logic              fast;
  logic              decision_pending;
  logic              decision_choice;

  // Results predicted but not yet seen on the result channel.
  res_t outcome_q[$];

  initial fail_count_o = 0;

  // Returns the session to idle and drops any countdown or held decision.
  task automatic close_session();
    sess_phase       = PH_IDLE;
    sess_screen      = SC_REQUEST;
    countdown        = '0;
    countdown_armed  = 1'b0;
    decision_pending = 1'b0;
    decision_choice  = 1'b0;
  endtask

  // Applies one event to the mirrored state and gives the expected result.
  task automatic predict_outcome(input item_t ev, output res_t res);
    logic active;
    active = (sess_phase == PH_HOME) || (sess_phase == PH_HOLDING) ||
             (sess_phase == PH_CONFIRMED);
    res = '0;
    if (ev.opcode == OP_START) begin
      close_session();
      sess_phase = PH_HOME;
      acked      = ev.preset_acked;
      fast       = ev.immediate_mode;
    end else if (active) begin
      case (ev.opcode) inside
        OP_TICK: begin
          if (countdown_armed) begin
            countdown = countdown - 1'b1;
            if (countdown == '0) begin
              countdown_armed = 1'b0;
              sess_phase      = PH_CONFIRMED;
              sess_screen     = SC_CONFIRMED;
            end
          end
        end
        OP_PRESS: begin
          if (acked && sess_phase == PH_HOME) begin
            sess_phase      = PH_HOLDING;
            sess_screen     = SC_ANIMATION;
            countdown_armed = 1'b1;
            // A zero hold length behaves as a single tick.
            if (fast || hold_len == '0) countdown = 16'd1;
            else countdown = hold_len;
          end
        end
        OP_RELEASE: begin
          if (sess_phase == PH_HOLDING) begin
            sess_phase      = PH_HOME;
            sess_screen     = SC_REQUEST_STILL;
            countdown_armed = 1'b0;
            countdown       = '0;
          end else if (sess_phase == PH_CONFIRMED) begin
            sess_phase       = PH_FINISHED;
            sess_screen      = SC_FINISHED;
            countdown_armed  = 1'b0;
            countdown        = '0;
            decision_pending = 1'b0;
            res.session_done = 1'b1;
            res.approved     = 1'b1;
          end
        end
        OP_HOST_ACK: begin
          acked = 1'b1;
          // A decision made before the acknowledge takes effect now.
          if (decision_pending) begin
            res.session_done = 1'b1;
            res.approved     = decision_choice;
            res.by_debug     = 1'b1;
            close_session();
          end
        end
        OP_HOST_CANCEL, OP_HOST_INIT: begin
          res.session_done = 1'b1;
          res.host_reset   = (ev.opcode == OP_HOST_INIT);
          close_session();
        end
        default: begin
          if (debug_allowed) begin
            decision_pending = 1'b1;
            decision_choice  = ev.decision_yes;
            if (acked) begin
              res.session_done = 1'b1;
              res.approved     = ev.decision_yes;
              res.by_debug     = 1'b1;
              close_session();
            end
          end
        end
      endcase
    end
    res.phase  = sess_phase;
    res.screen = sess_screen;
  endtask

  // Reports one field that differs from its prediction.
  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // Track configuration writes, predict on accepted events and compare
  // every accepted result transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t predicted;
    res_t wanted;
    res_t observed;
    if (!rst_ni) begin
      hold_len      = HoldTicksRst;
      debug_allowed = 1'b0;
      close_session();
      acked         = 1'b0;
      fast          = 1'b0;
      outcome_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgHoldTicks: hold_len = cfg_data_i[TicksW-1:0];
          CfgDebugEn:   debug_allowed = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_outcome(item_t'(s_axis_tdata[$bits(item_t)-1:0]), predicted);
        outcome_q.push_back(predicted);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        observed = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
        if (outcome_q.size() == 0) begin
          $error("result transaction with no prediction outstanding");
          fail_count_o++;
        end else begin
          wanted = outcome_q.pop_front();
          check_field("phase", wanted.phase, observed.phase);
          check_field("screen", wanted.screen, observed.screen);
          check_field("session_done", wanted.session_done, observed.session_done);
          check_field("approved", wanted.approved, observed.approved);
          check_field("host_reset", wanted.host_reset, observed.host_reset);
          check_field("by_debug", wanted.by_debug, observed.by_debug);
        end
      end
    end
    outstanding_o = outcome_q.size();
  end

endmodule

// File: bench/tb_hold_to_confirm_controller_core.sv
// ----------------------------------------------------------------------------
// tb_hold_to_confirm_controller_core
// Drives the hold-to-confirm controller with a short directed sequence and
// then with random sessions under several hold lengths and debug settings,
// with random gaps on both streams and one long stall of the receiver. The
// checker beside the block predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_hold_to_confirm_controller_core;
  import hcc_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned LongHoldOff  = 300;
  localparam int unsigned ItemsPerStep = 250;
  localparam int unsigned NumSettings  = 7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned cycle_count = 0;
  int unsigned sent_count = 0;

  // Settings currently programmed, used to shape the sessions.
  logic [TicksW-1:0] cur_hold = HoldTicksRst;
  logic              cur_debug = 1'b0;

  // Control of the random gaps on both streams.
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit rx_hold_req = 1'b0;
  bit rx_hold_done = 1'b0;

  hold_to_confirm_controller_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  hcc_session_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Clock with a period of four units.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Watchdog on the length of the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Offers one event and waits for its transaction, then perhaps a gap.
  task automatic send_event(input op_e op, input logic imm, input logic pre,
                            input logic yes);
    item_t ev;
    ev.opcode         = op;
    ev.immediate_mode = imm;
    ev.preset_acked   = pre;
    ev.decision_yes   = yes;
    s_axis_tdata  <= InDataW'(ev);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    if (!tx_quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // An event with every field drawn at random.
  task automatic send_noise();
    send_event(op_e'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // An event of the given kind with random values in the fields it ignores.
  task automatic send_op(input op_e op);
    send_event(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
  endtask

  // Stops offering events and waits until every result has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes both registers while the block is idle.
  task automatic program_setup(input logic [TicksW-1:0] hold, input logic dbg);
    cfg_index_i <= CfgHoldTicks;
    cfg_data_i  <= CfgDataW'(hold);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CfgDebugEn;
    cfg_data_i  <= CfgDataW'(dbg);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_hold  = hold;
    cur_debug = dbg;
  endtask

  // Mostly well-formed sessions with random content, some stray events.
  task automatic run_sessions(input int unsigned count);
    int unsigned target;
    int unsigned span;
    int unsigned ticks;
    int unsigned ending;
    logic        imm;
    logic        pre;
    target = sent_count + count;
    while (sent_count < target) begin
      if ($urandom_range(0, 9) < 2) begin
        send_noise();
      end else begin
        imm = ($urandom_range(0, 3) == 0);
        pre = 1'($urandom_range(0, 1));
        send_event(OP_START, imm, pre, 1'($urandom_range(0, 1)));
        if (!pre || $urandom_range(0, 3) == 0) begin
          if (cur_debug && $urandom_range(0, 3) == 0) send_op(OP_DEBUG);
          send_op(OP_HOST_ACK);
        end
        send_op(OP_PRESS);
        // Count the ticks against the hold length, short holds in full.
        if (imm || cur_hold <= 16'd1) span = 1;
        else if (cur_hold > 16'd8) span = 8;
        else span = 32'(cur_hold);
        ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, span) : span;
        repeat (ticks) begin
          if ($urandom_range(0, 15) == 0) send_noise();
          else send_op(OP_TICK);
        end
        ending = $urandom_range(0, 9);
        case (ending)
          6: send_op(OP_HOST_CANCEL);
          7: send_op(OP_HOST_INIT);
          8: send_op(OP_DEBUG);
          9: ;
          default: send_op(OP_RELEASE);
        endcase
      end
    end
  endtask

  // Receiver: ready most of the time, random stalls, one long hold-off.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req && !rx_hold_done) begin
        rx_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LongHoldOff) @(posedge clk_i);
      end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Main sequence: reset, directed events, random sessions, verdict.
  initial begin
    logic [TicksW-1:0] hold_set[NumSettings];
    logic              debug_set[NumSettings];
    hold_set  = '{16'd1, 16'd3, 16'hFFFF, 16'd2, 16'd0, 16'd4, 16'd1};
    debug_set = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With no session open everything but a start is ignored.
    send_event(OP_TICK, 1'b1, 1'b1, 1'b1);
    send_event(OP_RELEASE, 1'b0, 1'b0, 1'b0);
    send_event(OP_DEBUG, 1'b1, 1'b1, 1'b1);
    // Fast session, press before acknowledge, release while holding.
    send_event(OP_START, 1'b1, 1'b0, 1'b0);
    send_event(OP_PRESS, 1'b0, 1'b0, 1'b0);
    send_event(OP_HOST_ACK, 1'b0, 1'b0, 1'b0);
    send_event(OP_PRESS, 1'b0, 1'b0, 1'b0);
    send_event(OP_RELEASE, 1'b0, 1'b0, 1'b0);
    send_event(OP_PRESS, 1'b0, 1'b0, 1'b0);
    send_event(OP_TICK, 1'b0, 1'b0, 1'b0);
    send_event(OP_PRESS, 1'b0, 1'b0, 1'b0);
    send_event(OP_RELEASE, 1'b0, 1'b0, 1'b0);
    send_event(OP_HOST_CANCEL, 1'b0, 1'b0, 1'b0);
    // Long hold interrupted by a restart; debug decisions still disabled.
    send_event(OP_START, 1'b0, 1'b1, 1'b1);
    send_event(OP_PRESS, 1'b0, 1'b0, 1'b0);
    send_event(OP_TICK, 1'b0, 1'b0, 1'b0);
    send_event(OP_START, 1'b0, 1'b1, 1'b0);
    send_event(OP_DEBUG, 1'b0, 1'b0, 1'b1);
    send_event(OP_HOST_CANCEL, 1'b1, 1'b1, 1'b1);
    send_event(OP_START, 1'b1, 1'b1, 1'b0);
    send_event(OP_HOST_INIT, 1'b0, 1'b0, 1'b0);
    send_event(OP_HOST_INIT, 1'b0, 1'b0, 1'b0);
    drain();

    // Zero hold length and debug decisions, held and immediate.
    program_setup(16'd0, 1'b1);
    send_event(OP_START, 1'b0, 1'b0, 1'b0);
    send_event(OP_DEBUG, 1'b0, 1'b0, 1'b1);
    send_event(OP_DEBUG, 1'b0, 1'b0, 1'b0);
    send_event(OP_HOST_ACK, 1'b0, 1'b0, 1'b0);
    send_event(OP_START, 1'b0, 1'b1, 1'b0);
    send_event(OP_PRESS, 1'b0, 1'b0, 1'b0);
    send_event(OP_TICK, 1'b0, 1'b0, 1'b0);
    send_event(OP_DEBUG, 1'b0, 1'b0, 1'b1);
    drain();

    // Random sessions under each setting; the last runs without gaps.
    for (int i = 0; i < NumSettings; i++) begin
      program_setup(hold_set[i], debug_set[i]);
      if (i == 0) rx_hold_req = 1'b1;
      if (i == NumSettings - 1) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
      end
      run_sessions(ItemsPerStep);
      drain();
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hcc_pkg.sv
rtl/hcc_cfg_regs.sv
rtl/hcc_in_reg.sv
rtl/hcc_session.sv
rtl/hold_to_confirm_controller_core.sv
bench/hcc_session_checker.sv
bench/tb_hold_to_confirm_controller_core.sv
